// File: rtl/gwtu_pkg.sv
// Package for the GPS week/TOW to UTC calendar converter.
// Holds the item and result structs, the calendar constants and month tables.
// No dependencies.
package gwtu_pkg;

	typedef struct packed {
		logic [11:0] week_number;
		logic [19:0] tow_seconds;
		logic [19:0] tow_fraction_us;
	} item_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [8:0]  yday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [19:0] fraction_us;
		logic        before_epoch;
	} result_t;

	localparam logic [19:0] SECS_PER_WEEK    = 20'd604800;
	localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN     = 6'd60;
	localparam logic [8:0]  DAYS_IN_YEAR     = 9'd365;
	localparam logic [10:0] DAYS_PER_4Y      = 11'd1461;
	localparam logic [11:0] EPOCH_YEAR       = 12'd1980;
	localparam logic [2:0]  EPOCH_DAY_OFFSET = 3'd5;
	localparam logic [7:0]  LEAP_RESET       = 8'd17;

	// leap-day count bias: one 4-year cycle, minus Mar 1 of a leap year, plus epoch offset
	localparam logic [10:0] LEAP_BIAS = 11'd1406;

	// reciprocals for constant division, floor-rounded; each estimate is low by at most one
	localparam logic [25:0] RECIP_DAY  = 26'((64'd1 << 35) / 64'd675);   // /86400 after >>7
	localparam logic [15:0] RECIP_4Y   = 16'((64'd1 << 26) / 64'd1461);
	localparam logic [15:0] RECIP_YEAR = 16'((64'd1 << 24) / 64'd365);
	localparam logic [13:0] RECIP_225  = 14'((64'd1 << 21) / 64'd225);   // /3600 after >>4
	localparam logic [12:0] RECIP_60   = 13'((64'd1 << 18) / 64'd60);

	localparam logic [8:0] MONTH_START_COMMON [0:12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
	};
	localparam logic [8:0] MONTH_START_LEAP [0:12] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
	};

endpackage

// File: rtl/gps_week_tow_to_utc_calendar_core.sv
// A start transfer passes through the registered stages and the output register to the done strobe.
// Throughput: one timestamp per cycle; busy stays low, the pipeline never stalls.
// The leap second register is the only config; its write is taken in any cycle.
// Reset (arst_n low, async) clears all stage valids and loads leap_seconds = 17.
// Uses gwtu_pkg.
module gps_week_tow_to_utc_calendar_core
	import gwtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic [7:0] leap_q;

	logic [9:1] vld_s;

	// stage payloads
	logic [31:0] wk_prod_s1;
	logic [19:0] tow_s1;
	logic [31:0] utc_s2, utc_s3;
	logic [15:0] q0_s3;
	logic [14:0] days_s4, days_s5, days_s6, days_s7, days_s8;
	logic [16:0] sod_s4, sod_s5;
	logic [15:0] a_s5;
	logic [5:0]  lq_s5, ld_s6;
	logic [5:0]  hq_s5;
	logic [4:0]  hour_s6, hour_s7, hour_s8, hour_s9;
	logic [11:0] hrem_s6, hrem_s7;
	logic [15:0] b_s7;
	logic [6:0]  yq_s7, years_s8;
	logic [5:0]  mq_s7, minute_s8, minute_s9;
	logic [5:0]  second_s8, second_s9;
	logic [8:0]  doy0_s9;
	logic [11:0] year_s9;
	logic        leap_s9;
	logic [9:2]  before_s;
	logic [19:0] frac_s [1:9];
	result_t     res_s10;
	logic        vld_s10;

	logic accept;
	assign accept    = start && !busy;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = vld_s10;
	assign result    = res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leap_q <= LEAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			leap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s   <= {vld_s[8:1], accept};
			vld_s10 <= vld_s[9];
		end
	end

	// stage 2: seconds since epoch minus leap seconds
	logic [32:0] gps_sec;
	assign gps_sec = {1'b0, wk_prod_s1} + 33'(tow_s1);

	// stage 3: day quotient estimate
	logic [50:0] dprod;
	assign dprod = 51'(utc_s2[31:7]) * 51'(RECIP_DAY);

	// stage 4: correct day quotient, seconds of day
	logic [31:0] r0;
	logic        dsel;
	assign r0   = utc_s3 - 32'(q0_s3) * 32'(SECS_PER_DAY);
	assign dsel = r0 >= 32'(SECS_PER_DAY);

	// stage 5: leap-day and hour estimates
	logic [15:0] a_c;
	logic [31:0] lprod;
	logic [26:0] hprod;
	assign a_c   = 16'(days_s4) + 16'(LEAP_BIAS);
	assign lprod = 32'(a_c) * 32'(RECIP_4Y);
	assign hprod = 27'(sod_s4[16:4]) * 27'(RECIP_225);

	// stage 6: corrections
	logic [15:0] lrem;
	logic [16:0] hrem;
	logic        hsel;
	assign lrem = a_s5 - 16'(lq_s5) * 16'(DAYS_PER_4Y);
	assign hrem = sod_s5 - 17'(hq_s5) * 17'(SECS_PER_HOUR);
	assign hsel = hrem >= 17'(SECS_PER_HOUR);

	// stage 7: year and minute estimates
	logic [15:0] b_c;
	logic [31:0] yprod;
	logic [24:0] mprod;
	assign b_c   = 16'(days_s6) + 16'(EPOCH_DAY_OFFSET) - 16'(ld_s6);
	assign yprod = 32'(b_c) * 32'(RECIP_YEAR);
	assign mprod = 25'(hrem_s6) * 25'(RECIP_60);

	// stage 8: corrections
	logic [15:0] yrem;
	logic [11:0] mrem;
	logic        msel;
	assign yrem = b_s7 - 16'(yq_s7) * 16'(DAYS_IN_YEAR);
	assign mrem = hrem_s7 - 12'(mq_s7) * 12'(SECS_PER_MIN);
	assign msel = mrem >= 12'(SECS_PER_MIN);

	// stage 9: day of year, calendar year
	logic [5:0]  prior;
	logic [15:0] doy0;
	assign prior = 6'((8'(years_s8) + 8'd3) >> 2);
	assign doy0  = 16'(days_s8) + 16'(EPOCH_DAY_OFFSET)
		- 16'(years_s8) * 16'(DAYS_IN_YEAR) - 16'(prior);

	// stage 10: month search over the cumulative table
	logic [3:0] mon;
	logic [8:0] mstart;
	result_t    res_c;
	always_comb begin
		mon    = 4'd12;
		mstart = leap_s9 ? MONTH_START_LEAP[11] : MONTH_START_COMMON[11];
		for (int i = 12; i >= 1; i--) begin
			if (doy0_s9 < (leap_s9 ? MONTH_START_LEAP[i] : MONTH_START_COMMON[i])) begin
				mon    = 4'(i);
				mstart = leap_s9 ? MONTH_START_LEAP[i-1] : MONTH_START_COMMON[i-1];
			end
		end
		if (before_s[9]) begin
			res_c.year         = EPOCH_YEAR;
			res_c.month        = 4'd1;
			res_c.day          = 5'd6;
			res_c.yday         = 9'd6;
			res_c.hour         = '0;
			res_c.minute       = '0;
			res_c.second       = '0;
			res_c.fraction_us  = '0;
			res_c.before_epoch = 1'b1;
		end else begin
			res_c.year         = year_s9;
			res_c.month        = mon;
			res_c.day          = 5'(doy0_s9 - mstart + 9'd1);
			res_c.yday         = doy0_s9 + 9'd1;
			res_c.hour         = hour_s9;
			res_c.minute       = minute_s9;
			res_c.second       = second_s9;
			res_c.fraction_us  = frac_s[9];
			res_c.before_epoch = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wk_prod_s1 <= 32'(item.week_number) * 32'(SECS_PER_WEEK);
		tow_s1     <= item.tow_seconds;
		frac_s[1]  <= item.tow_fraction_us;

		utc_s2      <= 32'(gps_sec - 33'(leap_q));
		before_s[2] <= gps_sec < 33'(leap_q);

		utc_s3 <= utc_s2;
		q0_s3  <= dprod[50:35];

		days_s4 <= dsel ? 15'(q0_s3 + 16'd1) : 15'(q0_s3);
		sod_s4  <= dsel ? 17'(r0 - 32'(SECS_PER_DAY)) : 17'(r0);

		a_s5    <= a_c;
		lq_s5   <= lprod[31:26];
		hq_s5   <= hprod[26:21];
		sod_s5  <= sod_s4;
		days_s5 <= days_s4;

		ld_s6   <= (lrem >= 16'(DAYS_PER_4Y)) ? lq_s5 + 6'd1 : lq_s5;
		hour_s6 <= hsel ? 5'(hq_s5 + 6'd1) : 5'(hq_s5);
		hrem_s6 <= hsel ? 12'(hrem - 17'(SECS_PER_HOUR)) : 12'(hrem);
		days_s6 <= days_s5;

		b_s7    <= b_c;
		yq_s7   <= yprod[30:24];
		mq_s7   <= mprod[23:18];
		hrem_s7 <= hrem_s6;
		hour_s7 <= hour_s6;
		days_s7 <= days_s6;

		years_s8  <= (yrem >= 16'(DAYS_IN_YEAR)) ? yq_s7 + 7'd1 : yq_s7;
		minute_s8 <= msel ? mq_s7 + 6'd1 : mq_s7;
		second_s8 <= msel ? 6'(mrem - 12'(SECS_PER_MIN)) : 6'(mrem);
		hour_s8   <= hour_s7;
		days_s8   <= days_s7;

		doy0_s9   <= doy0[8:0];
		year_s9   <= EPOCH_YEAR + 12'(years_s8);
		leap_s9   <= years_s8[1:0] == 2'd0;
		hour_s9   <= hour_s8;
		minute_s9 <= minute_s8;
		second_s9 <= second_s8;

		for (int k = 2; k <= 9; k++) begin
			frac_s[k] <= frac_s[k-1];
		end
		for (int k = 3; k <= 9; k++) begin
			before_s[k] <= before_s[k-1];
		end

		res_s10 <= res_c;
	end

endmodule

// File: rtl/gwtu_checker.sv
// Port-level checks for the GPS week/TOW to UTC calendar converter.
// Uses gwtu_pkg; bound to gps_week_tow_to_utc_calendar_core.
module gwtu_checker
	import gwtu_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input item_t      item,
	input logic       done,
	input result_t    result
);

	localparam int LATENCY = 10;

	// every result traces back to an earlier start transfer
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done without matching start");

	// a start transfer always yields a result after the latency
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("start transfer lost");

	// pre-epoch results carry the clamped epoch date
	a_before_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.before_epoch) |->
			(result.year == EPOCH_YEAR && result.month == 4'd1 && result.day == 5'd6
			&& result.yday == 9'd6 && result.hour == 5'd0
			&& result.minute == 6'd0 && result.second == 6'd0
			&& result.fraction_us == 20'd0))
		else $error("pre-epoch result not clamped");

	// calendar fields stay in range for normal results
	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.before_epoch) |->
			(result.month >= 4'd1 && result.month <= 4'd12 && result.day >= 5'd1
			&& result.yday >= 9'd1 && result.yday <= 9'd366
			&& result.hour <= 5'd23 && result.minute <= 6'd59 && result.second <= 6'd59))
		else $error("result field out of range");

	// the microsecond fraction rides through unchanged
	a_frac_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.before_epoch) |->
			result.fraction_us == $past(item.tow_fraction_us, LATENCY))
		else $error("fraction not passed through");

endmodule

bind gps_week_tow_to_utc_calendar_core gwtu_checker u_gwtu_checker (.*);

// File: test/gps_week_tow_to_utc_calendar_core_test.sv
// Testbench for gps_week_tow_to_utc_calendar_core: directed corner timestamps, then random
// timestamps under several leap second settings, checked against a local calendar predictor.
// Depends on gwtu_pkg and the core RTL only.
module gps_week_tow_to_utc_calendar_core_test;
	import gwtu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		item_t   ts;
		bit      typed;
		result_t want;
	} stim_row_t;

	// the clamp value for any time before the epoch, with the flag set
	localparam result_t EPOCH_CLAMP =
		'{12'd1980, 4'd1, 5'd6, 9'd6, 5'd0, 6'd0, 6'd0, 20'd0, 1'b1};

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	item_t      item;
	logic       done;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	logic [7:0] leap_now;
	bit         cur_typed;
	result_t    cur_want;
	result_t    want;
	result_t    expected_utc [$];
	stim_row_t  directed [$];
	int         n_items, n_results, n_before, n_errors, n_settings;
	int         burst_left;

	gps_week_tow_to_utc_calendar_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [8:0] month_bound(input bit leap_yr, input int idx);
		return leap_yr ? MONTH_START_LEAP[idx] : MONTH_START_COMMON[idx];
	endfunction

	// calendar breakdown of one GPS timestamp for a given GPS-UTC offset
	function automatic result_t utc_of(input item_t ts, input logic [7:0] leap);
		longint unsigned gps, utc, days, sod, from_jan1, leap_days, years, prior, doy0, yr;
		longint unsigned hr, rem, mn, dom;
		int      m;
		bit      leap_yr;
		result_t r;
		gps = longint'(ts.week_number) * longint'(SECS_PER_WEEK) + longint'(ts.tow_seconds);
		if (gps < longint'(leap))
			return EPOCH_CLAMP;
		utc       = gps - longint'(leap);
		days      = utc / longint'(SECS_PER_DAY);
		sod       = utc - days * longint'(SECS_PER_DAY);
		from_jan1 = days + longint'(EPOCH_DAY_OFFSET);
		// leap days so far, counting the current cycle's one only after Feb
		leap_days = (from_jan1 + longint'(DAYS_PER_4Y) - longint'(MONTH_START_LEAP[2]))
			/ longint'(DAYS_PER_4Y);
		years     = (from_jan1 - leap_days) / longint'(DAYS_IN_YEAR);
		prior     = (years + 3) / 4;
		doy0      = from_jan1 - years * longint'(DAYS_IN_YEAR) - prior;
		yr        = longint'(EPOCH_YEAR) + years;
		leap_yr   = (yr[1:0] == 2'd0);
		m = 12;
		for (int i = 12; i >= 1; i--)
			if (doy0 < longint'(month_bound(leap_yr, i)))
				m = i;
		dom = doy0 - longint'(month_bound(leap_yr, m - 1)) + 1;
		hr  = sod / longint'(SECS_PER_HOUR);
		if (hr > 23)
			hr = 23;
		rem = sod - hr * longint'(SECS_PER_HOUR);
		mn  = rem / 60;
		if (mn > 59)
			mn = 59;
		r.year         = yr[11:0];
		r.month        = 4'(m);
		r.day          = dom[4:0];
		r.yday         = 9'(doy0 + 1);
		r.hour         = hr[4:0];
		r.minute       = mn[5:0];
		r.second       = 6'(rem - mn * 60);
		r.fraction_us  = ts.tow_fraction_us;
		r.before_epoch = 1'b0;
		return r;
	endfunction

	// result check and input transfer capture share the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_utc.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: result with nothing pending: %p", $time, result);
				end else begin
					want = expected_utc.pop_front();
					n_results++;
					if (result.before_epoch)
						n_before++;
					if (result.year !== want.year || result.month !== want.month ||
						result.day !== want.day || result.yday !== want.yday ||
						result.hour !== want.hour || result.minute !== want.minute ||
						result.second !== want.second || result.fraction_us !== want.fraction_us ||
						result.before_epoch !== want.before_epoch) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("%0t: mismatch exp %0d-%0d-%0d doy %0d %0d:%0d:%0d.%0d be %0b",
								$time, want.year, want.month, want.day, want.yday, want.hour,
								want.minute, want.second, want.fraction_us, want.before_epoch);
							$display("    got %0d-%0d-%0d doy %0d %0d:%0d:%0d.%0d be %0b",
								result.year, result.month, result.day, result.yday,
								result.hour, result.minute, result.second, result.fraction_us,
								result.before_epoch);
						end
					end
				end
			end
			if (start && !busy) begin
				expected_utc.push_back(cur_typed ? cur_want : utc_of(item, leap_now));
				n_items++;
			end
		end
	end

	task automatic idle(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// one timestamp transfer, then a random gap once the current burst runs out
	task automatic send(input item_t ts, input bit typed, input result_t exp_r);
		@(negedge clk);
		start     = 1'b1;
		item      = ts;
		cur_typed = typed;
		cur_want  = exp_r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			idle($urandom_range(1, 7));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
	endtask

	// hold off until every pending result is back
	task automatic settle();
		idle(1);
		while (expected_utc.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_leap(input logic [7:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		leap_now = v;
		n_settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_row(input int wn, input int tow, input int frac, input bit typed,
		input result_t exp_r);
		stim_row_t row;
		row.ts.week_number     = 12'(wn);
		row.ts.tow_seconds     = 20'(tow);
		row.ts.tow_fraction_us = 20'(frac);
		row.typed              = typed;
		row.want               = exp_r;
		directed.push_back(row);
	endtask

	function automatic item_t random_ts();
		item_t ts;
		int    sel;
		sel = $urandom_range(0, 9);
		ts.week_number     = 12'($urandom_range(0, 4095));
		ts.tow_seconds     = 20'($urandom_range(0, 604799));
		ts.tow_fraction_us = 20'($urandom_range(0, 999999));
		case (sel)
			0: begin
				// around the epoch and the leap offset
				ts.week_number = '0;
				ts.tow_seconds = 20'($urandom_range(0, 300));
			end
			1: begin
				ts.tow_seconds     = 20'($urandom());
				ts.tow_fraction_us = 20'($urandom());
			end
			2, 3: begin
				// just before or after a UTC midnight
				ts.tow_seconds = 20'($urandom_range(0, 6) * 86400 + leap_now +
					(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(86398, 86399)));
			end
			default: ;
		endcase
		return ts;
	endfunction

	initial begin
		logic [7:0] settings [5];
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		cur_typed  = 1'b0;
		cur_want   = '0;
		leap_now   = LEAP_RESET;
		burst_left = 3;
		settings   = '{8'd0, 8'd255, 8'd18, 8'($urandom_range(1, 254)), 8'd17};

		// the first rows lean on the reset value of the offset
		add_row(0, 0, 0, 1, EPOCH_CLAMP);
		add_row(0, 16, 999999, 1, EPOCH_CLAMP);
		add_row(0, 17, 123, 1, '{12'd1980, 4'd1, 5'd6, 9'd6, 5'd0, 6'd0, 6'd0, 20'd123, 1'b0});
		add_row(0, 604799, 0, 0, '0);
		add_row(1, 700000, 500000, 0, '0);
		add_row(7, 475217, 1, 0, '0);
		add_row(7, 518417, 2, 0, '0);
		add_row(51, 345616, 999999, 0, '0);
		add_row(51, 345617, 0, 0, '0);
		add_row(4095, 604799, 999999, 0, '0);
		add_row(4095, 20'hFFFFF, 20'hFFFFF, 0, '0);
		add_row(12'hAAA, 20'hAAAAA, 20'h55555, 0, '0);
		add_row(12'h555, 20'h55555, 20'hAAAAA, 0, '0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send(directed[i].ts, directed[i].typed, directed[i].want);

		foreach (settings[s]) begin
			settle();
			set_leap(settings[s]);
			repeat (140)
				send(random_ts(), 1'b0, '0);
		end

		settle();
		repeat (20) @(posedge clk);
		if (expected_utc.size() != 0) begin
			n_errors++;
			$display("%0d results never arrived", expected_utc.size());
		end
		$display("%0d timestamps sent, %0d converted across %0d offset settings",
			n_items, n_results, n_settings + 1);
		$display("%0d clamped before epoch, %0d errors", n_before, n_errors);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

endmodule
